### sv/sigmoid_polynomial_spectrum_eval_macros.svh
// Assertion macros for the sigmoid polynomial evaluator
`ifndef SIGMOID_POLYNOMIAL_SPECTRUM_EVAL_MACROS_SVH
`define SIGMOID_POLYNOMIAL_SPECTRUM_EVAL_MACROS_SVH
`define SPE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/spe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;
   localparam int MaxCoeffs = 6;
   localparam int NumCoefRegs = 6;
   localparam int CoefW = 32;
   localparam int WaveW = 17;
   localparam int ResW = 16;
   localparam int CsrIdxW = 3;
   localparam int SqrtSteps = 33;
   localparam int DivSteps = 16;
   localparam logic [CsrIdxW-1:0] RegCoefCount = 3'd6;
   localparam logic [WaveW-1:0] OneQ16 = 17'h10000;

   // data handed along the Horner chain
   typedef struct packed {
      logic                   valid;
      logic signed [CoefW-1:0] x;
      logic [WaveW-1:0]       w;
      logic [2:0]             left;
      logic                   sat;
   } horner_type;

   // data handed along the square root and divider chain
   typedef struct packed {
      logic        valid;
      logic        neg;
      logic        sat;
      logic [31:0] ax;
      logic [65:0] rem;
      logic [33:0] root;
      logic [65:0] d;
      logic [47:0] num;
      logic [16:0] quo;
   } sig_type;
endpackage
`default_nettype wire

### sv/spe_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spe_req_if;
   logic                        valid;
   logic                        ready;
   logic [spe_pkg::WaveW-1:0]   wavelength_norm;
   modport source (output valid, output wavelength_norm, input ready);
   modport sink (input valid, input wavelength_norm, output ready);
endinterface

interface spe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spe_pkg::ResW-1:0]    sigmoid_value;
   logic                        saturated;
   modport source (output valid, output sigmoid_value, output saturated, input ready);
   modport sink (input valid, input sigmoid_value, input saturated, output ready);
endinterface

interface spe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [spe_pkg::CsrIdxW-1:0]   index;
   logic [spe_pkg::CoefW-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/sigmoid_polynomial_spectrum_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// Evaluates a polynomial of up to six Q16.16 coefficients at a Q1.16 wavelength and maps it
// through 0.5*x/sqrt(x*x+1)+0.5. One transaction is taken every clock; the whole row stalls
// while a finished result is not taken. Stages: 5 Horner cells, 1 setup, 33 square-root
// cells, 1 setup, 17 divider cells, 1 output register. The block relies on the user to
// write coefficients through the csr port only while the pipeline is empty.
`include "sigmoid_polynomial_spectrum_eval_macros.svh"
module sigmoid_polynomial_spectrum_eval (
   input  wire logic   clock,
   input  wire logic   reset,
   spe_req_if.sink     req,
   spe_rsp_if.source   rsp,
   spe_csr_if.sink     csr
);
   localparam int NH = spe_pkg::MaxCoeffs - 1;
   localparam int NS = spe_pkg::SqrtSteps;
   localparam int ND = spe_pkg::DivSteps + 1;

   logic signed [spe_pkg::CoefW-1:0] coef_ff [spe_pkg::NumCoefRegs];
   logic [2:0] count_ff;
   logic enable;
   logic rsp_valid_ff;
   logic [spe_pkg::ResW-1:0] res_ff, res_in;
   logic sat_ff, sat_in;

   spe_pkg::horner_type hchain [NH+1];
   spe_pkg::sig_type sset_ff, sset_in;
   spe_pkg::sig_type schain [NS+1];
   spe_pkg::sig_type dset_ff, dset_in;
   spe_pkg::sig_type dchain [ND+1];
   logic [2:0] n_eff;
   logic [spe_pkg::WaveW-1:0] w_clamp;

   assign enable = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spe_pkg::NumCoefRegs; i++) coef_ff[i] <= '0;
         count_ff <= 3'd3;
      end else if (csr.valid) begin
         if (csr.index == spe_pkg::RegCoefCount) begin
            count_ff <= csr.data[2:0];
         end else if (csr.index < spe_pkg::RegCoefCount) begin
            coef_ff[csr.index] <= csr.data;
         end
      end
   end

   always_comb begin
      n_eff = count_ff;
      if (n_eff == 3'd0) n_eff = 3'd1;
      if (n_eff > 3'(spe_pkg::MaxCoeffs)) n_eff = 3'(spe_pkg::MaxCoeffs);
      w_clamp = (req.wavelength_norm > spe_pkg::OneQ16) ? spe_pkg::OneQ16
                                                        : req.wavelength_norm;
      hchain[0].valid = req.valid;
      hchain[0].x = coef_ff[0];
      hchain[0].w = w_clamp;
      hchain[0].left = n_eff - 3'd1;
      hchain[0].sat = 1'b0;
   end

   for (genvar g = 0; g < NH; g++) begin : g_horner
      spe_horner_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .coef(coef_ff[g + 1]), .prev(hchain[g]), .next(hchain[g + 1])
      );
   end

   // Coefficient stage g uses coef g+1; cells skip once the remaining count is spent,
   // but the count must be measured from the start, so skip is keyed to left.
   always_comb begin
      logic [31:0] ax;
      ax = hchain[NH].x[31] ? 32'(-hchain[NH].x) : 32'(hchain[NH].x);
      sset_in = '0;
      sset_in.valid = hchain[NH].valid;
      sset_in.neg = hchain[NH].x[31];
      sset_in.sat = hchain[NH].sat;
      sset_in.ax = ax;
      sset_in.rem = 66'(64'(ax) * 64'(ax)) + (66'd1 << 32);
   end

   always_ff @(posedge clock) begin
      if (reset) sset_ff.valid <= 1'b0;
      else if (enable) sset_ff.valid <= sset_in.valid;
      if (enable) begin
         sset_ff.neg <= sset_in.neg;
         sset_ff.sat <= sset_in.sat;
         sset_ff.ax <= sset_in.ax;
         sset_ff.rem <= sset_in.rem;
         sset_ff.root <= sset_in.root;
         sset_ff.d <= sset_in.d;
         sset_ff.num <= sset_in.num;
         sset_ff.quo <= sset_in.quo;
      end
   end

   assign schain[0] = sset_ff;
   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      spe_sigmoid_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable), .is_div(1'b0),
         .bitpos(7'(NS - 1 - g)), .prev(schain[g]), .next(schain[g + 1])
      );
   end

   always_comb begin
      dset_in = schain[NS];
      dset_in.d = 66'(schain[NS].root);
      dset_in.num = 48'({schain[NS].ax, 15'd0}) + 48'(schain[NS].root >> 1);
      dset_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) dset_ff.valid <= 1'b0;
      else if (enable) dset_ff.valid <= dset_in.valid;
      if (enable) begin
         dset_ff.neg <= dset_in.neg;
         dset_ff.sat <= dset_in.sat;
         dset_ff.ax <= dset_in.ax;
         dset_ff.rem <= dset_in.rem;
         dset_ff.root <= dset_in.root;
         dset_ff.d <= dset_in.d;
         dset_ff.num <= dset_in.num;
         dset_ff.quo <= dset_in.quo;
      end
   end

   assign dchain[0] = dset_ff;
   for (genvar g = 0; g < ND; g++) begin : g_div
      spe_sigmoid_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable), .is_div(1'b1),
         .bitpos(7'(ND - 1 - g)), .prev(dchain[g]), .next(dchain[g + 1])
      );
   end

   always_comb begin
      logic [17:0] up;
      up = 18'd32768 + 18'(dchain[ND].quo);
      sat_in = dchain[ND].sat;
      if (!dchain[ND].neg) begin
         if (up > 18'd65535) begin
            res_in = 16'hFFFF;
            sat_in = 1'b1;
         end else begin
            res_in = up[15:0];
         end
      end else begin
         res_in = (dchain[ND].quo >= 17'd32768) ? 16'd0 : 16'(17'd32768 - dchain[ND].quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dchain[ND].valid;
      end
      if (enable) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.sigmoid_value = res_ff;
   assign rsp.saturated = sat_ff;

   `SPE_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.sigmoid_value), "result changed while stalled")
   `SPE_ASSERT_IMPL(a_ready_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready,
      "input taken while output stalled")
   `SPE_ASSERT_IMPL(a_ready_idle, clock, reset, !rsp.valid, req.ready,
      "input refused while output empty")
endmodule
`default_nettype wire

### sv/spe_horner_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module spe_horner_cell (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic signed [spe_pkg::CoefW-1:0] coef,
   input  wire spe_pkg::horner_type              prev,
   output      spe_pkg::horner_type              next
);
   spe_pkg::horner_type next_ff, next_in;
   logic signed [49:0] prod;
   logic signed [34:0] rnd;
   logic signed [35:0] sum;

   always_comb begin
      prod = prev.x * $signed({1'b0, prev.w});
      rnd = 35'(($signed(prod) + 50'sd32768) >>> 16);
      sum = 36'(rnd) + 36'(coef);
      next_in = prev;
      if (prev.left != 3'd0) begin
         next_in.left = prev.left - 3'd1;
         if (sum > 36'sh07FFFFFFF) begin
            next_in.x = 32'sh7FFFFFFF;
            next_in.sat = 1'b1;
         end else if (sum < -36'sh080000000) begin
            next_in.x = 32'sh80000000;
            next_in.sat = 1'b1;
         end else begin
            next_in.x = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (enable) begin
         next_ff.valid <= prev.valid;
      end
      if (enable) begin
         next_ff.x <= next_in.x;
         next_ff.w <= next_in.w;
         next_ff.left <= next_in.left;
         next_ff.sat <= next_in.sat;
      end
   end

   assign next = next_ff;
endmodule
`default_nettype wire

### sv/spe_sigmoid_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One bit of the integer square root, or one quotient bit of the divider.
module spe_sigmoid_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              is_div,
   input  wire logic [6:0]        bitpos,
   input  wire spe_pkg::sig_type  prev,
   output      spe_pkg::sig_type  next
);
   spe_pkg::sig_type next_ff, next_in;
   logic [67:0] trial;
   logic [66:0] bitv;
   logic [48:0] dtrial;
   logic [48:0] shifted;

   always_comb begin
      next_in = prev;
      bitv = 67'd1 << (2 * bitpos);
      trial = 68'(prev.root) << (bitpos + 7'd1);
      trial = trial + 68'(bitv);
      shifted = 49'(prev.d[33:0]) << bitpos;
      dtrial = shifted;
      if (!is_div) begin
         if (68'(prev.rem) >= trial) begin
            next_in.rem = 66'(68'(prev.rem) - trial);
            next_in.root = prev.root | (34'd1 << bitpos);
         end
      end else begin
         if (49'(prev.num) >= dtrial) begin
            next_in.num = 48'(49'(prev.num) - dtrial);
            next_in.quo = prev.quo | (17'd1 << bitpos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (enable) begin
         next_ff.valid <= prev.valid;
      end
      if (enable) begin
         next_ff.neg <= next_in.neg;
         next_ff.sat <= next_in.sat;
         next_ff.ax <= next_in.ax;
         next_ff.rem <= next_in.rem;
         next_ff.root <= next_in.root;
         next_ff.d <= next_in.d;
         next_ff.num <= next_in.num;
         next_ff.quo <= next_in.quo;
      end
   end

   assign next = next_ff;
endmodule
`default_nettype wire
